[hw/rtl/rsc_pkg.sv]
package rsc_pkg;

    // Opcodes on s_op
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // Status codes on m_status
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    // Width of the reported levels
    localparam int LEVEL_W = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_ITER,
        S_COMMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the input item
        logic decode;   // check the item, set up mul/div
        logic step;     // one mul/div iteration
        logic commit;   // update the stack and status
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_iter;   // item is an accepted mul or div
        logic iter_done;    // all iterations finished
    } dp_status_t;

endpackage

[hw/rtl/rpn_stack_calculator.sv]
// RPN stack calculator, one result item per input item.
// Every item is loaded in idle, checked in decode and applied to the stack in commit;
// commit waits for a free result slot, m_valid is registered from it, and the next
// item is taken only back in idle. Accepted multiply and divide items also iterate,
// one bit per cycle, in the shift-add / restoring-divide unit before commit.
// Reset (aresetn low, synchronous) clears all stack levels and the result flag.
module rpn_stack_calculator
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = 4,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_op,
    input  logic signed [LEVEL_W-1:0]  s_push_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [LEVEL_W-1:0]  m_level_x,
    output logic signed [LEVEL_W-1:0]  m_level_y,
    output logic signed [LEVEL_W-1:0]  m_level_z,
    output logic signed [LEVEL_W-1:0]  m_level_t,
    output logic [2:0]                 m_status
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Sequencer
    rsc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    // Stack and arithmetic
    rsc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .dp_cmd       (dp_cmd),
        .dp_status    (dp_status),
        .s_op         (s_op),
        .s_push_value (s_push_value),
        .m_level_x    (m_level_x),
        .m_level_y    (m_level_y),
        .m_level_z    (m_level_z),
        .m_level_t    (m_level_t),
        .m_status     (m_status)
    );

endmodule

[hw/rtl/rsc_ctrl.sv]
module rsc_ctrl
    import rsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    // Result slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = dp_status.needs_iter ? S_ITER : S_COMMIT;
            end
            S_ITER: begin
                if (dp_status.iter_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        dp_cmd  = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                dp_cmd.load = s_valid;
            end
            S_DECODE: begin
                dp_cmd.decode = 1'b1;
            end
            S_ITER: begin
                dp_cmd.step = !dp_status.iter_done;
            end
            S_COMMIT: begin
                dp_cmd.commit = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        if (dp_cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/rsc_datapath.sv]
module rsc_datapath
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = 4,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dp_cmd_t                    dp_cmd,
    output dp_status_t                 dp_status,
    input  logic [2:0]                 s_op,
    input  logic signed [LEVEL_W-1:0]  s_push_value,
    output logic signed [LEVEL_W-1:0]  m_level_x,
    output logic signed [LEVEL_W-1:0]  m_level_y,
    output logic signed [LEVEL_W-1:0]  m_level_z,
    output logic signed [LEVEL_W-1:0]  m_level_t,
    output logic [2:0]                 m_status
);

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    // Item capture
    logic [2:0]                op_reg, op_next;
    logic signed [LEVEL_W-1:0] val_reg, val_next;

    // Stack, X at index 0
    logic [W-1:0] stack_reg [STACK_DEPTH];
    logic [W-1:0] stack_next [STACK_DEPTH];
    logic [2:0]   st_reg, st_next;
    logic [2:0]   out_st_reg, out_st_next;

    // Shared shift-add / restoring-divide unit
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     opa_reg, opa_next;
    logic [W-1:0]     opb_reg, opb_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [W-1:0] x_word, y_word, push_word, mag_x, mag_y, result;
    logic [63:0]  push_ext;
    logic [2:0]   pre_status;
    logic         pre_iter;
    logic [W:0]   trial;

    assign x_word = stack_reg[0];
    assign y_word = stack_reg[1];
    assign mag_x  = x_word[W-1] ? (W'(0) - x_word) : x_word;
    assign mag_y  = y_word[W-1] ? (W'(0) - y_word) : y_word;

    // Sign-extend from 32 bits, then keep the stack width
    assign push_ext  = 64'(val_reg);
    assign push_word = push_ext[W-1:0];

    // Item check
    always_comb begin
        pre_status = ST_OK;
        pre_iter   = 1'b0;
        if (op_reg == OP_PUSH) begin
            if (stack_reg[STACK_DEPTH-1] != '0) begin
                pre_status = ST_FULL;
            end
        end else if (x_word == '0 && y_word == '0) begin
            pre_status = ST_EMPTY;
        end else begin
            unique case (op_reg) inside
                OP_ADD, OP_SUB: pre_status = ST_OK;
                OP_MUL:         pre_iter   = 1'b1;
                OP_DIV: begin
                    if (x_word == '0) begin
                        pre_status = ST_DIVZERO;
                    end else begin
                        pre_iter = 1'b1;
                    end
                end
                default:        pre_status = ST_INVALID;
            endcase
        end
    end

    assign dp_status.needs_iter = pre_iter;
    assign dp_status.iter_done  = (cnt_reg == '0);

    // Trial subtract for one divide step
    assign trial = {acc_reg, opa_reg[W-1]} - {1'b0, opb_reg};

    // Arithmetic result
    always_comb begin
        case (op_reg)
            OP_ADD:  result = y_word + x_word;
            OP_SUB:  result = y_word - x_word;
            OP_MUL:  result = acc_reg;
            default: result = neg_reg ? (W'(0) - opa_reg) : opa_reg;
        endcase
    end

    // Item and status registers
    always_comb begin
        op_next     = op_reg;
        val_next    = val_reg;
        st_next     = st_reg;
        out_st_next = out_st_reg;
        if (dp_cmd.load) begin
            op_next  = s_op;
            val_next = s_push_value;
        end
        if (dp_cmd.decode) begin
            st_next = pre_status;
        end
        // reported status changes only with the result item
        if (dp_cmd.commit) begin
            out_st_next = st_reg;
        end
    end

    // Iteration unit
    always_comb begin
        acc_next = acc_reg;
        opa_next = opa_reg;
        opb_next = opb_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        if (dp_cmd.decode) begin
            acc_next = '0;
            cnt_next = pre_iter ? CNT_W'(DATA_WIDTH) : '0;
            if (op_reg == OP_MUL) begin
                opa_next = y_word;
                opb_next = x_word;
            end else begin
                opa_next = mag_y;
                opb_next = mag_x;
            end
            neg_next = x_word[W-1] ^ y_word[W-1];
        end else if (dp_cmd.step) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (op_reg == OP_MUL) begin
                acc_next = acc_reg + (opb_reg[0] ? opa_reg : '0);
                opa_next = {opa_reg[W-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[W-1:1]};
            end else if (!trial[W]) begin
                acc_next = trial[W-1:0];
                opa_next = {opa_reg[W-2:0], 1'b1};
            end else begin
                acc_next = {acc_reg[W-2:0], opa_reg[W-1]};
                opa_next = {opa_reg[W-2:0], 1'b0};
            end
        end
    end

    // Stack update on commit
    always_comb begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            stack_next[i] = stack_reg[i];
        end
        if (dp_cmd.commit && st_reg == ST_OK) begin
            if (op_reg == OP_PUSH) begin
                for (int i = STACK_DEPTH - 1; i > 0; i--) begin
                    stack_next[i] = stack_reg[i-1];
                end
                stack_next[0] = push_word;
            end else begin
                stack_next[0] = result;
                for (int i = 1; i < STACK_DEPTH - 1; i++) begin
                    stack_next[i] = stack_reg[i+1];
                end
                stack_next[STACK_DEPTH-1] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
                stack_reg[i] <= '0;
            end
            st_reg     <= ST_OK;
            out_st_reg <= ST_OK;
            cnt_reg    <= '0;
        end else begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
                stack_reg[i] <= stack_next[i];
            end
            st_reg     <= st_next;
            out_st_reg <= out_st_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        val_reg <= val_next;
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        neg_reg <= neg_next;
    end

    // Reported levels: low 32 bits, zero above the stack depth
    logic [LEVEL_W-1:0] level [4];

    for (genvar j = 0; j < 4; j++) begin : g_level
        if (j < STACK_DEPTH) begin : g_used
            assign level[j] = LEVEL_W'(stack_reg[j]);
        end else begin : g_unused
            assign level[j] = '0;
        end
    end

    assign m_level_x = level[0];
    assign m_level_y = level[1];
    assign m_level_z = level[2];
    assign m_level_t = level[3];
    assign m_status  = out_st_reg;

endmodule

[tb/rsc_calc_checker.sv]
// Watches both channels of the calculator, predicts each result item from the
// accepted input items and compares the two field by field.
module rsc_calc_checker
    import rsc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [2:0]                 s_op,
    input  logic signed [LEVEL_W-1:0]  s_push_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [LEVEL_W-1:0]  m_level_x,
    input  logic signed [LEVEL_W-1:0]  m_level_y,
    input  logic signed [LEVEL_W-1:0]  m_level_z,
    input  logic signed [LEVEL_W-1:0]  m_level_t,
    input  logic [2:0]                 m_status,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic signed [LEVEL_W-1:0] x;
        logic signed [LEVEL_W-1:0] y;
        logic signed [LEVEL_W-1:0] z;
        logic signed [LEVEL_W-1:0] t;
        logic [2:0]                status;
    } calc_result_t;

    // Shadow stack: index 0 is X, index 3 is T
    logic signed [LEVEL_W-1:0] shadow_lvl [4];
    calc_result_t              calc_q [$];
    int                        n_fail = 0;

    task automatic report_mismatch(input string msg);
        if (n_fail < 40) begin
            $display("[%0t] calc mismatch: %s", $realtime, msg);
        end
        n_fail++;
    endtask

    // Apply one item to the shadow stack and return the result it should give
    task automatic apply_item(input logic [2:0] op, input logic signed [LEVEL_W-1:0] val,
                              output calc_result_t res);
        logic signed [LEVEL_W-1:0] x;
        logic signed [LEVEL_W-1:0] y;
        logic signed [LEVEL_W-1:0] r;
        logic [LEVEL_W-1:0]        mag_n;
        logic [LEVEL_W-1:0]        mag_d;
        logic [LEVEL_W-1:0]        quo;
        logic [2:0]                st;
        st = ST_OK;
        r  = '0;
        if (op == OP_PUSH) begin
            if (shadow_lvl[3] != 0) begin
                st = ST_FULL;
            end else begin
                shadow_lvl[3] = shadow_lvl[2];
                shadow_lvl[2] = shadow_lvl[1];
                shadow_lvl[1] = shadow_lvl[0];
                shadow_lvl[0] = val;
            end
        end else begin
            x = shadow_lvl[0];
            y = shadow_lvl[1];
            // empty check comes ahead of the opcode check
            if (x == 0 && y == 0) begin
                st = ST_EMPTY;
            end else begin
                case (op)
                    OP_ADD: r = y + x;
                    OP_SUB: r = y - x;
                    OP_MUL: r = y * x;
                    OP_DIV: begin
                        if (x == 0) begin
                            st = ST_DIVZERO;
                        end else begin
                            // truncate toward zero on magnitudes, then fix the sign
                            mag_n = y[LEVEL_W-1] ? (~y + 1'b1) : y;
                            mag_d = x[LEVEL_W-1] ? (~x + 1'b1) : x;
                            quo   = mag_n / mag_d;
                            if (x[LEVEL_W-1] ^ y[LEVEL_W-1]) begin
                                quo = ~quo + 1'b1;
                            end
                            r = quo;
                        end
                    end
                    default: st = ST_INVALID;
                endcase
            end
            if (st == ST_OK) begin
                shadow_lvl[0] = r;
                shadow_lvl[1] = shadow_lvl[2];
                shadow_lvl[2] = shadow_lvl[3];
                shadow_lvl[3] = '0;
            end
        end
        res.x      = shadow_lvl[0];
        res.y      = shadow_lvl[1];
        res.z      = shadow_lvl[2];
        res.t      = shadow_lvl[3];
        res.status = st;
    endtask

    // Check delivered items first, then predict the newly accepted one
    always @(posedge aclk) begin : watch
        calc_result_t got;
        calc_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                shadow_lvl[i] = '0;
            end
            calc_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_level_x, m_level_y, m_level_z, m_level_t, m_status};
                if (calc_q.size() == 0) begin
                    report_mismatch($sformatf("result item with none expected (status %0d)",
                                              m_status));
                end else begin
                    want = calc_q.pop_front();
                    if (got.x !== want.x)
                        report_mismatch($sformatf("level_x got %0d exp %0d", got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("level_y got %0d exp %0d", got.y, want.y));
                    if (got.z !== want.z)
                        report_mismatch($sformatf("level_z got %0d exp %0d", got.z, want.z));
                    if (got.t !== want.t)
                        report_mismatch($sformatf("level_t got %0d exp %0d", got.t, want.t));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d exp %0d",
                                                  got.status, want.status));
                end
            end
            if (s_valid && s_ready) begin
                apply_item(s_op, s_push_value, want);
                calc_q.push_back(want);
            end
        end
        fail_count <= n_fail;
        pending    <= calc_q.size();
    end

endmodule

[tb/tb_rpn_stack_calculator.sv]
// Stimulus and verdict for the RPN stack calculator; checking lives in the checker.
module tb_rpn_stack_calculator;
    import rsc_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_RANDOM     = 2000;

    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic [2:0]                 s_op         = OP_PUSH;
    logic signed [LEVEL_W-1:0]  s_push_value = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic signed [LEVEL_W-1:0]  m_level_x;
    logic signed [LEVEL_W-1:0]  m_level_y;
    logic signed [LEVEL_W-1:0]  m_level_z;
    logic signed [LEVEL_W-1:0]  m_level_t;
    logic [2:0]                 m_status;
    int                         fail_count;
    int                         pending;

    bit                         tx_idle_on = 1'b1;

    rpn_stack_calculator i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_level_x    (m_level_x),
        .m_level_y    (m_level_y),
        .m_level_z    (m_level_z),
        .m_level_t    (m_level_t),
        .m_status     (m_status)
    );

    rsc_calc_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_level_x    (m_level_x),
        .m_level_y    (m_level_y),
        .m_level_z    (m_level_z),
        .m_level_t    (m_level_t),
        .m_status     (m_status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic [2:0] op, input logic [LEVEL_W-1:0] val);
        int gap;
        gap = tx_idle_on ? $urandom_range(13, 0) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_op         <= op;
        s_push_value <= val;
        s_valid      <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Stop offering until every expected item has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Push values weighted toward zero, small numbers and the extremes
    function automatic logic [LEVEL_W-1:0] pick_value();
        case ($urandom_range(9, 0))
            0, 1, 2: pick_value = $urandom_range(40, 0) - 20;
            3:       pick_value = '0;
            4:       pick_value = 32'h8000_0000;
            5:       pick_value = 32'h7fff_ffff;
            6:       pick_value = '1;
            default: pick_value = $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_op();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 42)      pick_op = OP_PUSH;
        else if (roll < 55) pick_op = OP_ADD;
        else if (roll < 68) pick_op = OP_SUB;
        else if (roll < 81) pick_op = OP_MUL;
        else if (roll < 94) pick_op = OP_DIV;
        else                pick_op = 3'(roll % 3 + 5);
    endfunction

    // Result side: random stalls, quiet stretches, and two long hold-offs
    initial begin : result_sink
        int n_taken;
        int gap;
        bit rx_idle_on;
        n_taken    = 0;
        rx_idle_on = 1'b1;
        @(posedge aclk iff aresetn);
        forever begin
            if (n_taken % 64 == 0) begin
                rx_idle_on = ($urandom_range(3, 0) != 0);
            end
            gap = rx_idle_on ? $urandom_range(13, 0) : 0;
            if (n_taken == 150 || n_taken == 1300) begin
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            n_taken++;
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        logic [2:0] op;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty stack: each valid operator and one invalid one are refused as empty
        send_item(OP_ADD, $urandom);
        send_item(3'd5, $urandom);
        send_item(OP_DIV, $urandom);
        send_item(OP_MUL, $urandom);
        send_item(OP_SUB, $urandom);
        // invalid operators once the stack holds something
        send_item(OP_PUSH, 32'd7);
        send_item(3'd6, $urandom);
        send_item(3'd7, $urandom);
        // divide by zero, then subtract zero
        send_item(OP_PUSH, 32'd0);
        send_item(OP_DIV, $urandom);
        send_item(OP_SUB, $urandom);
        // most negative over minus one
        send_item(OP_PUSH, 32'h8000_0000);
        send_item(OP_PUSH, 32'hffff_ffff);
        send_item(OP_DIV, $urandom);
        // fill to T, then a refused push
        send_item(OP_PUSH, 32'h7fff_ffff);
        send_item(OP_PUSH, 32'd1);
        send_item(OP_PUSH, 32'd5);
        // wrapping add and multiply
        send_item(OP_ADD, $urandom);
        send_item(OP_MUL, $urandom);
        // negative quotient truncates toward zero
        send_item(OP_PUSH, -32'sd7);
        send_item(OP_PUSH, 32'd2);
        send_item(OP_DIV, $urandom);
        send_item(OP_PUSH, 32'h7fff_ffff);
        send_item(OP_MUL, $urandom);
        send_item(OP_SUB, $urandom);
        wait_drained();

        // random operation streams
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 50 == 0) begin
                tx_idle_on = ($urandom_range(3, 0) != 0);
            end
            if (i == N_RANDOM / 2) begin
                wait_drained();
            end
            op = pick_op();
            send_item(op, (op == OP_PUSH) ? pick_value() : $urandom);
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS rpn_stack_calculator");
        end else begin
            $display("FAIL rpn_stack_calculator");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #1000000;
        $display("FAIL rpn_stack_calculator");
        $finish;
    end

endmodule
